### src/mhpq_pkg.sv
package mhpq_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Request codes
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic ext;
    } cell_cmd_t;

endpackage

### src/mhpq_cell.sv
module mhpq_cell (
    input  logic               clk,
    input  mhpq_pkg::cell_cmd_t cmd,
    input  mhpq_pkg::key_t     new_key,
    input  logic               occ_self,
    input  logic               occ_prev,
    input  mhpq_pkg::key_t     prev_key,
    input  mhpq_pkg::key_t     next_key,
    output mhpq_pkg::key_t     key_q
);
    import mhpq_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic keep_self;
    logic prev_stays;

    // Row is kept sorted ascending from cell 0; unoccupied cells act as +infinity
    assign keep_self  = occ_self && (key_reg <= new_key);
    assign prev_stays = occ_prev && (prev_key <= new_key);

    always_comb
    begin
        key_next = key_reg;
        if (cmd.ins)
        begin
            if (keep_self)
                key_next = key_reg;
            else if (prev_stays)
                key_next = new_key;
            else
                key_next = prev_key;
        end
        else if (cmd.ext)
        begin
            // shift towards the head
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

### src/min_heap_priority_queue_unit.sv
// Min-priority queue held as a sorted row of DEPTH cells (cell 0 holds the minimum).
// The result is registered as the item is accepted; every cell updates in the same cycle.
// Throughput: one item per cycle while no result is stalled; cells update from their neighbours.
// An item is taken while a result waits if that result is taken in the same cycle.
// Reset (rst_n low, asynchronous) empties the queue and clears the result valid.
module min_heap_priority_queue_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  mhpq_pkg::key_t                    key_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mhpq_pkg::key_t                    key_out,
    output logic [mhpq_pkg::STAT_W-1:0]       status,
    output logic [mhpq_pkg::COUNT_W-1:0]      count
);
    import mhpq_pkg::*;

    cnt_t                count_reg;
    cnt_t                count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    key_t                key_out_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic                accept;
    logic                full;
    logic                empty;
    logic [STAT_W-1:0]   status_now;
    key_t                result_key;
    cell_cmd_t           cmd;

    key_t                cell_key [DEPTH];
    logic [DEPTH-1:0]    occ;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // Decode request against the current fill level
    always_comb
    begin
        status_now = ST_DONE;
        result_key = '0;
        cmd        = '0;
        count_next = count_reg;
        case (req_type)
            REQ_INSERT:
            begin
                if (full)
                    status_now = ST_FULL;
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_EXTRACT:
            begin
                if (empty)
                    status_now = ST_EMPTY;
                else
                begin
                    cmd.ext    = accept;
                    result_key = cell_key[0];
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_now = ST_DONE;
            end
        endcase
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            key_t prev_k;
            key_t next_k;
            logic prev_o;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                // head sees a neighbour that always stays ahead
                assign prev_o = 1'b1;
                assign prev_k = {1'b1, {(KEY_W-1){1'b0}}};
            end
            else
            begin : g_body
                assign prev_o = occ[gi-1];
                assign prev_k = cell_key[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_k = cell_key[gi];
            end
            else
            begin : g_mid
                assign next_k = cell_key[gi+1];
            end

            mhpq_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .new_key  (key_in),
                .occ_self (occ[gi]),
                .occ_prev (prev_o),
                .prev_key (prev_k),
                .next_key (next_k),
                .key_q    (cell_key[gi])
            );
        end
    endgenerate

    // Output valid handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_out_reg   <= result_key;
            status_reg    <= status_now;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

### src/mhpq_checker.sv
module mhpq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              req_type,
    input  mhpq_pkg::key_t                    key_in,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  mhpq_pkg::key_t                    key_out,
    input  logic [mhpq_pkg::STAT_W-1:0]       status,
    input  logic [mhpq_pkg::COUNT_W-1:0]      count
);
    import mhpq_pkg::*;

    // A waiting request holds its item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(key_in))
        else $error("request changed while waiting");

    // A stalled result holds its item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_out) && $stable(status)
            && $stable(count))
        else $error("result changed while stalled");

    // Only a successful extract carries a key
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> key_out == '0)
        else $error("non-zero key on failed request");

    // Empty status only when nothing is stored
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with entries stored");

    // Full status only at capacity
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH))
        else $error("full status below capacity");

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (.*);
